// ===== rtl/core/ctmpj_pkg.sv =====
// shared constants, types and tables for the constant-turn prediction core
package ctmpj_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int MAX_STEPS        = 24;

  localparam logic signed [35:0] CORDIC_X0 = 36'sd652032874;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] speed;
    logic        [15:0] heading;
    logic signed [23:0] turn_rate;
    logic        [15:0] time_step;
  } item_t;

  typedef struct packed {
    logic               vld;
    item_t              itm;
    logic               flip;
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [33:0] z;
  } cell_t;

  function automatic logic signed [33:0] atan_val(input int i);
    case (i)
      0:  atan_val = 34'sd536870912;
      1:  atan_val = 34'sd316933406;
      2:  atan_val = 34'sd167458907;
      3:  atan_val = 34'sd85004756;
      4:  atan_val = 34'sd42667331;
      5:  atan_val = 34'sd21354465;
      6:  atan_val = 34'sd10679838;
      7:  atan_val = 34'sd5340245;
      8:  atan_val = 34'sd2670163;
      9:  atan_val = 34'sd1335087;
      10: atan_val = 34'sd667544;
      11: atan_val = 34'sd333772;
      12: atan_val = 34'sd166886;
      13: atan_val = 34'sd83443;
      14: atan_val = 34'sd41722;
      15: atan_val = 34'sd20861;
      16: atan_val = 34'sd10430;
      17: atan_val = 34'sd5215;
      18: atan_val = 34'sd2608;
      19: atan_val = 34'sd1304;
      20: atan_val = 34'sd652;
      21: atan_val = 34'sd326;
      22: atan_val = 34'sd163;
      23: atan_val = 34'sd81;
      default: atan_val = 34'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sh7FFFFFFF) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -50'sh80000000) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== rtl/core/ctmpj_cell.sv =====
// one cordic rotation cell of the chain
module ctmpj_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctmpj_pkg::cell_t din,
  output ctmpj_pkg::cell_t dout
);

  ctmpj_pkg::cell_t dout_nxt;
  ctmpj_pkg::cell_t dout_r;

  always_comb begin
    dout_nxt = din;
    if (din.z >= 0) begin
      dout_nxt.x = din.x - (din.y >>> STAGE);
      dout_nxt.y = din.y + (din.x >>> STAGE);
      dout_nxt.z = din.z - ctmpj_pkg::atan_val(STAGE);
    end else begin
      dout_nxt.x = din.x + (din.y >>> STAGE);
      dout_nxt.y = din.y - (din.x >>> STAGE);
      dout_nxt.z = din.z + ctmpj_pkg::atan_val(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r <= '0;
    end else begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

// ===== rtl/core/ctmpj_post.sv =====
// trig rounding, products, saturation and output register
module ctmpj_post (
  input  logic               clk,
  input  logic               rst_n,
  input  ctmpj_pkg::cell_t   din,
  output logic               vld,
  output logic signed [31:0] nx,
  output logic signed [31:0] ny,
  output logic signed [31:0] nv,
  output logic        [15:0] nh,
  output logic signed [23:0] nw,
  output logic signed [31:0] dxv,
  output logic signed [31:0] dxh,
  output logic signed [31:0] dyv,
  output logic signed [31:0] dyh
);

  // stage a: trig to q1.15, v*dt, w*dt
  logic signed [21:0] cr, sr;
  logic signed [15:0] c_nxt, s_nxt;
  logic signed [15:0] c_r, s_r;
  logic signed [48:0] vdt_r;
  logic signed [40:0] wdt_r;
  logic               va_r;
  ctmpj_pkg::item_t   ia_r;

  function automatic logic signed [15:0] trig(input logic signed [21:0] r, input logic f);
    logic signed [22:0] t;
    t = f ? -{r[21], r} : {r[21], r};
    if (t > 23'sd32767) trig = 16'sh7FFF;
    else if (t < -23'sd32768) trig = 16'sh8000;
    else trig = t[15:0];
  endfunction

  always_comb begin
    cr = 22'((din.x + 36'sd16384) >>> 15);
    sr = 22'((din.y + 36'sd16384) >>> 15);
    c_nxt = trig(cr, din.flip);
    s_nxt = trig(sr, din.flip);
  end

  always_ff @(posedge clk) begin
    c_r   <= c_nxt;
    s_r   <= s_nxt;
    vdt_r <= din.itm.speed * $signed({1'b0, din.itm.time_step});
    wdt_r <= din.itm.turn_rate * $signed({1'b0, din.itm.time_step});
    ia_r  <= din.itm;
    va_r  <= rst_n ? din.vld : 1'b0;
  end

  // stage b: products
  logic signed [64:0] pc_r, ps_r;
  logic signed [32:0] dc_r, ds_r;
  logic        [15:0] h_r;
  logic               vb_r;
  ctmpj_pkg::item_t   ib_r;
  logic signed [40:0] wq;

  assign wq = (wdt_r + 41'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    pc_r <= vdt_r * c_r;
    ps_r <= vdt_r * s_r;
    dc_r <= $signed({1'b0, ia_r.time_step}) * c_r;
    ds_r <= $signed({1'b0, ia_r.time_step}) * s_r;
    h_r  <= ia_r.heading + wq[15:0];
    ib_r <= ia_r;
    vb_r <= rst_n ? va_r : 1'b0;
  end

  // stage c: rounding, sums and saturation
  logic signed [34:0] pcr, psr, npsr;
  logic signed [18:0] dcr, dsr;
  logic signed [49:0] sx, sy;

  always_comb begin
    pcr  = 35'((pc_r + 65'sh40000000) >>> 31);
    psr  = 35'((ps_r + 65'sh40000000) >>> 31);
    npsr = 35'((-ps_r + 65'sh40000000) >>> 31);
    dcr  = 19'((dc_r + 33'sd16384) >>> 15);
    dsr  = 19'((ds_r + 33'sd16384) >>> 15);
    sx   = 50'(ib_r.pos_x) + 50'(pcr);
    sy   = 50'(ib_r.pos_y) + 50'(psr);
  end

  always_ff @(posedge clk) begin
    nx  <= ctmpj_pkg::sat32(sx);
    ny  <= ctmpj_pkg::sat32(sy);
    nv  <= ib_r.speed;
    nh  <= h_r;
    nw  <= ib_r.turn_rate;
    dxv <= ctmpj_pkg::sat32(50'(dcr));
    dyv <= ctmpj_pkg::sat32(50'(dsr));
    dxh <= ctmpj_pkg::sat32(50'(npsr));
    dyh <= ctmpj_pkg::sat32(50'(pcr));
    vld <= rst_n ? vb_r : 1'b0;
  end

endmodule

// ===== rtl/core/ct_motion_predict_jacobian_core.sv =====
// top level of the constant-turn motion prediction and jacobian core
// an item is taken in every cycle (busy stays low) and its result is shown
// for one cycle on out_valid after the angle-folding register, one register per
// cordic cell in the chain, and the registers for the trig rounding, the two
// multiplier stages and the saturating output register.
// results cannot be held off by the receiver.
module ct_motion_predict_jacobian_core #(
  parameter int CORDIC_STEPS = ctmpj_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ctmpj_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_speed,
  input  logic        [15:0] in_heading,
  input  logic signed [23:0] in_turn_rate,
  input  logic        [15:0] in_time_step,
  output logic               out_valid,
  output logic signed [31:0] out_next_pos_x,
  output logic signed [31:0] out_next_pos_y,
  output logic signed [31:0] out_next_speed,
  output logic        [15:0] out_next_heading,
  output logic signed [23:0] out_next_turn_rate,
  output logic signed [31:0] out_dx_dspeed,
  output logic signed [31:0] out_dx_dheading,
  output logic signed [31:0] out_dy_dspeed,
  output logic signed [31:0] out_dy_dheading
);

  localparam int NSTEP = (CORDIC_STEPS < ctmpj_pkg::MAX_STEPS) ? CORDIC_STEPS
                                                                : ctmpj_pkg::MAX_STEPS;

  ctmpj_pkg::cell_t chain [NSTEP+1];
  ctmpj_pkg::cell_t head_nxt;
  ctmpj_pkg::cell_t head_r;
  logic [31:0] a32;
  logic signed [33:0] z0;

  assign busy = 1'b0;

  always_comb begin
    a32 = {in_heading, 16'h0000} & ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    z0  = {{2{a32[31]}}, a32};
    head_nxt.vld  = start;
    head_nxt.itm  = '{in_pos_x, in_pos_y, in_speed, in_heading, in_turn_rate,
                      in_time_step};
    head_nxt.flip = 1'b0;
    head_nxt.x    = ctmpj_pkg::CORDIC_X0;
    head_nxt.y    = '0;
    if (z0 >= 34'sh40000000) begin
      head_nxt.z    = z0 - 34'sh80000000;
      head_nxt.flip = 1'b1;
    end else if (z0 < -34'sh40000000) begin
      head_nxt.z    = z0 + 34'sh80000000;
      head_nxt.flip = 1'b1;
    end else begin
      head_nxt.z    = z0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  assign chain[0] = head_r;

  for (genvar g = 0; g < NSTEP; g++) begin : g_cell
    ctmpj_cell #(.STAGE(g)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  ctmpj_post u_post (
    .clk  (clk),
    .rst_n(rst_n),
    .din  (chain[NSTEP]),
    .vld  (out_valid),
    .nx   (out_next_pos_x),
    .ny   (out_next_pos_y),
    .nv   (out_next_speed),
    .nh   (out_next_heading),
    .nw   (out_next_turn_rate),
    .dxv  (out_dx_dspeed),
    .dxh  (out_dx_dheading),
    .dyv  (out_dy_dspeed),
    .dyh  (out_dy_dheading)
  );

endmodule

// ===== rtl/core/ctmpj_checker.sv =====
// port-level checks for the prediction core
module ctmpj_checker #(
  parameter int CORDIC_STEPS = ctmpj_pkg::CORDIC_STEPS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] in_speed,
  input logic signed [23:0] in_turn_rate,
  input logic signed [31:0] out_next_speed,
  input logic signed [23:0] out_next_turn_rate
);

  localparam int LAT = ((CORDIC_STEPS < 24) ? CORDIC_STEPS : 24) + 4;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid) else $error("result missing");

  a_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT (out_next_speed == $past(in_speed, LAT)))
    else $error("speed not passed through");

  a_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT (out_next_turn_rate == $past(in_turn_rate, LAT)))
    else $error("turn rate not passed through");

endmodule

bind ct_motion_predict_jacobian_core ctmpj_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .in_speed(in_speed), .in_turn_rate(in_turn_rate), .out_next_speed(out_next_speed),
  .out_next_turn_rate(out_next_turn_rate)
);

// ===== tb/tb.sv =====
// self-checking testbench for the constant-turn motion prediction and jacobian core
module tb;

  localparam int LATENCY = ctmpj_pkg::CORDIC_STEPS_DEF + 4;
  localparam int WATCHDOG = 2000;

  typedef struct {
    logic signed [31:0] npx, npy, nspd;
    logic [15:0]        nhdg;
    logic signed [23:0] nw;
    logic signed [31:0] dxv, dxh, dyv, dyh;
  } track_pred_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_speed = '0;
  logic [15:0] in_heading = '0, in_time_step = '0;
  logic signed [23:0] in_turn_rate = '0;
  logic out_valid;
  logic signed [31:0] out_next_pos_x, out_next_pos_y, out_next_speed;
  logic [15:0] out_next_heading;
  logic signed [23:0] out_next_turn_rate;
  logic signed [31:0] out_dx_dspeed, out_dx_dheading, out_dy_dspeed, out_dy_dheading;

  ctmpj_pkg::item_t pending_items[$];
  track_pred_t expected_tracks[$];
  int errors = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;
  bit all_sent = 0;

  ct_motion_predict_jacobian_core dut (.*);

  always #6 clk = ~clk;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat_q(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic void heading_trig(logic [15:0] hdg, output longint sn, output longint cs);
    logic [31:0] ang;
    longint z, x, y, xs, ys;
    bit flip;
    ang = {hdg, 16'h0} & ~((32'd1 << (32 - ctmpj_pkg::ANGLE_BITS_DEF)) - 32'd1);
    z = longint'(ang);
    flip = 0;
    x = 652032874;
    y = 0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z >= 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < ctmpj_pkg::CORDIC_STEPS_DEF && i < ctmpj_pkg::MAX_STEPS; i++) begin
      xs = floor_sh(x, i);
      ys = floor_sh(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ctmpj_pkg::atan_val(i));
      end else begin
        x += ys; y -= xs; z += longint'(ctmpj_pkg::atan_val(i));
      end
    end
    x = round_sh(x, 15);
    y = round_sh(y, 15);
    if (flip) begin
      x = -x; y = -y;
    end
    cs = clip(x, -32768, 32767);
    sn = clip(y, -32768, 32767);
  endfunction

  function automatic track_pred_t predict_track(ctmpj_pkg::item_t it);
    track_pred_t r;
    longint sn, cs, vdt, pc, ps, dt, q;
    heading_trig(it.heading, sn, cs);
    dt = longint'(it.time_step);
    vdt = longint'(it.speed) * dt;
    pc = vdt * cs;
    ps = vdt * sn;
    q = round_sh(longint'(it.turn_rate) * dt, 16);
    r.npx = 32'(sat_q(longint'(it.pos_x) + round_sh(pc, 31)));
    r.npy = 32'(sat_q(longint'(it.pos_y) + round_sh(ps, 31)));
    r.nspd = it.speed;
    r.nhdg = it.heading + q[15:0];
    r.nw = it.turn_rate;
    r.dxv = 32'(sat_q(round_sh(dt * cs, 15)));
    r.dxh = 32'(sat_q(round_sh(-ps, 31)));
    r.dyv = 32'(sat_q(round_sh(dt * sn, 15)));
    r.dyh = 32'(sat_q(round_sh(pc, 31)));
    return r;
  endfunction

  function automatic logic [31:0] rnd32(int mode);
    case (mode)
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h7FFFFF)
                                     : -$urandom_range(0, 32'h7FFFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(logic [31:0] px, logic [31:0] py, logic [31:0] v, logic [15:0] h,
                          logic [23:0] w, logic [15:0] dt);
    ctmpj_pkg::item_t it;
    it.pos_x = px; it.pos_y = py; it.speed = v;
    it.heading = h; it.turn_rate = w; it.time_step = dt;
    pending_items.push_back(it);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && start && !busy) begin
      expected_tracks.push_back(predict_track(pending_items.pop_front()));
    end
    if (rst_n && pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
      start <= 1'b1;
      in_pos_x <= pending_items[0].pos_x;
      in_pos_y <= pending_items[0].pos_y;
      in_speed <= pending_items[0].speed;
      in_heading <= pending_items[0].heading;
      in_turn_rate <= pending_items[0].turn_rate;
      in_time_step <= pending_items[0].time_step;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    track_pred_t e;
    if (rst_n && out_valid) begin
      if (expected_tracks.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        e = expected_tracks.pop_front();
        if (out_next_pos_x !== e.npx) begin
          $error("next_pos_x exp %0d got %0d", e.npx, out_next_pos_x); errors++;
        end
        if (out_next_pos_y !== e.npy) begin
          $error("next_pos_y exp %0d got %0d", e.npy, out_next_pos_y); errors++;
        end
        if (out_next_speed !== e.nspd) begin
          $error("next_speed exp %0d got %0d", e.nspd, out_next_speed); errors++;
        end
        if (out_next_heading !== e.nhdg) begin
          $error("next_heading exp %0d got %0d", e.nhdg, out_next_heading); errors++;
        end
        if (out_next_turn_rate !== e.nw) begin
          $error("next_turn_rate exp %0d got %0d", e.nw, out_next_turn_rate); errors++;
        end
        if (out_dx_dspeed !== e.dxv) begin
          $error("dx_dspeed exp %0d got %0d", e.dxv, out_dx_dspeed); errors++;
        end
        if (out_dx_dheading !== e.dxh) begin
          $error("dx_dheading exp %0d got %0d", e.dxh, out_dx_dheading); errors++;
        end
        if (out_dy_dspeed !== e.dyv) begin
          $error("dy_dspeed exp %0d got %0d", e.dyv, out_dy_dspeed); errors++;
        end
        if (out_dy_dheading !== e.dyh) begin
          $error("dy_dheading exp %0d got %0d", e.dyh, out_dy_dheading); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (!all_sent || expected_tracks.size() > 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int phase_pct[4] = '{0, 56, 0, 25};
    // extremes, quadrant edges and the heading fold
    add_item(0, 0, 32'h00010000, 16'h0000, 0, 16'hFFFF);
    add_item(0, 0, 32'h00010000, 16'h4000, 0, 16'hFFFF);
    add_item(0, 0, 32'h00010000, 16'h8000, 0, 16'hFFFF);
    add_item(0, 0, 32'h00010000, 16'hC000, 0, 16'hFFFF);
    add_item(0, 0, 32'h00010000, 16'h3FFF, 0, 16'h8000);
    add_item(0, 0, 32'h00010000, 16'hBFFF, 0, 16'h8000);
    add_item(0, 0, 32'h00010000, 16'hFFFF, 0, 16'h0001);
    add_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h2000, 24'h7FFFFF, 16'hFFFF);
    add_item(32'h80000000, 32'h80000000, 32'h80000000, 16'hA000, 24'h800000, 16'hFFFF);
    add_item(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 16'h6000, 24'h800000, 16'hFFFF);
    add_item(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hE000, 24'h7FFFFF, 16'hFFFF);
    add_item(32'h12345678, 32'hEDCBA987, 32'h7FFFFFFF, 16'h1234, 24'h7FFFFF, 16'h0000);
    add_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
    add_item(0, 0, 0, 0, 0, 0);
    add_item(0, 0, 32'h80000000, 16'h0000, 24'h000001, 16'h8000);
    add_item(0, 0, 32'h80000000, 16'h4000, 24'hFFFFFF, 16'h8000);
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < 175; n++) begin
        add_item(rnd32($urandom_range(0, 9)), rnd32($urandom_range(0, 9)),
                 rnd32($urandom_range(0, 9)), 16'($urandom), 24'($urandom),
                 16'($urandom));
      end
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_pct[ph];
      while (pending_items.size() > (3 - ph) * 175) @(posedge clk);
    end
    while (pending_items.size() > 0) @(posedge clk);
    all_sent = 1;
    while (expected_tracks.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0 && expected_tracks.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
